/* sv/mam_pkg.sv */
// Shared word width, command codes and pipeline stage types for modular_add_mul.
package mam_pkg;

  localparam int WORD_BITS  = 64;
  localparam int HALF_BITS  = WORD_BITS / 2;
  localparam int HIGH_BITS  = WORD_BITS - HALF_BITS;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int DIV_STEPS  = PROD_BITS;
  localparam int PIPE_DEPTH = DIV_STEPS + 2;

  // Stream widths padded up to whole bytes.
  localparam int IN_DATA_BITS  = ((3 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((WORD_BITS + 7) / 8) * 8;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MUL = 1'b1;

  // Front stage: operands split into partial products.
  typedef struct packed {
    logic                             cmd;
    logic                             zero;
    logic [WORD_BITS-1:0]             a;
    logic [WORD_BITS-1:0]             b;
    logic [WORD_BITS-1:0]             m;
    logic [2*HALF_BITS-1:0]           pp_ll;
    logic [HALF_BITS+HIGH_BITS-1:0]   pp_lh;
    logic [HIGH_BITS+HALF_BITS-1:0]   pp_hl;
    logic [2*HIGH_BITS-1:0]           pp_hh;
  } front_t;

  // One step of the restoring reduction.
  typedef struct packed {
    logic                 zero;
    logic [WORD_BITS-1:0] m;
    logic [WORD_BITS-1:0] rem;
    logic [PROD_BITS-1:0] x;
  } div_t;

endpackage

/* sv/modular_add_mul.sv */
// Top level of modular_add_mul: pipelined (a+b) mod m and (a*b) mod m.
//
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tuser: command; tdata: operand_a, operand_b, modulus
// m_axis    out  tdata: remainder; tuser: zero_modulus
//
// One beat enters per cycle, except while the output stage holds a beat that is not taken.
// Stage 0 forms four half-width partial products, stage 1 adds them into the
// double-width product (or forms the sum), then 2*WORD_BITS restoring steps
// reduce that value one dividend bit per stage against the modulus.
// Reset clears only the valid bits; payload registers carry no reset.
// The whole pipe advances together whenever the last stage is empty or its
// beat is taken; bubbles fill as beats flow, so a stall loses nothing.
module modular_add_mul
  import mam_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // operand_a [63:0], operand_b [127:64], modulus [191:128]
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // command [0]
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // remainder [63:0]
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // zero_modulus [0]
  output logic                     m_axis_tuser
);

  logic [PIPE_DEPTH-1:0] vld;
  logic                  advance;

  front_t                front;
  div_t                  div [DIV_STEPS+1];
  div_t                  div_next [DIV_STEPS];
  div_t                  div_head;

  logic [WORD_BITS-1:0]  in_a, in_b, in_m;
  logic [PROD_BITS-1:0]  product;
  logic [WORD_BITS:0]    sum;

  // Move the whole pipe when the output stage is free or being drained.
  assign advance       = !vld[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = advance;

  assign in_a = s_axis_tdata[WORD_BITS-1:0];
  assign in_b = s_axis_tdata[WORD_BITS +: WORD_BITS];
  assign in_m = s_axis_tdata[2*WORD_BITS +: WORD_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: hold operands and form partial products.
  always_ff @(posedge clk) begin
    if (advance) begin
      front.cmd   <= s_axis_tuser;
      front.zero  <= (in_m == '0);
      front.a     <= in_a;
      front.b     <= in_b;
      front.m     <= in_m;
      front.pp_ll <= in_a[HALF_BITS-1:0] * in_b[HALF_BITS-1:0];
      front.pp_lh <= in_a[HALF_BITS-1:0] * in_b[WORD_BITS-1:HALF_BITS];
      front.pp_hl <= in_a[WORD_BITS-1:HALF_BITS] * in_b[HALF_BITS-1:0];
      front.pp_hh <= in_a[WORD_BITS-1:HALF_BITS] * in_b[WORD_BITS-1:HALF_BITS];
    end
  end

  // Stage 1: combine partial products, or take the carry-extended sum.
  always_comb begin
    product = PROD_BITS'(front.pp_ll)
            + (PROD_BITS'(front.pp_lh) << HALF_BITS)
            + (PROD_BITS'(front.pp_hl) << HALF_BITS)
            + (PROD_BITS'(front.pp_hh) << (2 * HALF_BITS));
    sum = {1'b0, front.a} + {1'b0, front.b};
    div_head.zero = front.zero;
    div_head.m    = front.m;
    div_head.rem  = '0;
    case (front.cmd)
      CMD_MUL: div_head.x = product;
      CMD_ADD: div_head.x = PROD_BITS'(sum);
      default: div_head.x = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      div[0] <= div_head;
    end
  end

  // Restoring reduction: shift one dividend bit in per stage, subtract when due.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [WORD_BITS:0] trial;
    always_comb begin
      trial = {div[k].rem, div[k].x[PROD_BITS-1]};
      if (trial >= {1'b0, div[k].m}) begin
        trial = trial - {1'b0, div[k].m};
      end
      div_next[k].zero = div[k].zero;
      div_next[k].m    = div[k].m;
      div_next[k].rem  = trial[WORD_BITS-1:0];
      div_next[k].x    = {div[k].x[PROD_BITS-2:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        div[k+1] <= div_next[k];
      end
    end
  end

  // Drive the result; a zero modulus forces the remainder to zero.
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];
  assign m_axis_tuser  = div[DIV_STEPS].zero;
  assign m_axis_tdata  = div[DIV_STEPS].zero ? '0
                       : OUT_DATA_BITS'(div[DIV_STEPS].rem);

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("zero modulus result not cleared");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !div[DIV_STEPS].zero |-> div[DIV_STEPS].rem < div[DIV_STEPS].m)
    else $error("remainder not below modulus");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled pipe moved");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted beat lost at entry");

endmodule

/* sim/tb.sv */
// Testbench for modular_add_mul: directed table plus random beats against a local predictor.
`timescale 1ns / 1ps
module tb;
  import mam_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                     s_axis_tuser = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;

  modular_add_mul i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    logic [WORD_BITS-1:0] rem;
    logic                 zero;
  } residue_t;

  // A row either carries a typed-in expectation or defers to the predictor.
  typedef struct {
    logic                 cmd;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] m;
    bit                   typed;
    residue_t             want;
  } operation_t;

  residue_t   pending_residues[$];
  operation_t ops[$];
  int         mismatches = 0;
  bit         stimulus_done = 1'b0;
  int         stall_hold = 0;

  // Exact residue of the full sum or product.
  function automatic residue_t predict_residue(operation_t op);
    residue_t r;
    logic [2*WORD_BITS-1:0] wide;
    r.zero = (op.m == '0);
    r.rem  = '0;
    if (!r.zero) begin
      if (op.cmd == CMD_ADD) wide = {{WORD_BITS{1'b0}}, op.a} + {{WORD_BITS{1'b0}}, op.b};
      else wide = {{WORD_BITS{1'b0}}, op.a} * {{WORD_BITS{1'b0}}, op.b};
      wide  = wide % {{WORD_BITS{1'b0}}, op.m};
      r.rem = wide[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic void add_row(logic cmd, logic [63:0] a, logic [63:0] b,
                                  logic [63:0] m);
    operation_t op;
    op.cmd       = cmd;
    op.a         = a;
    op.b         = b;
    op.m         = m;
    op.typed     = 1'b0;
    op.want.rem  = '0;
    op.want.zero = 1'b0;
    ops.push_back(op);
  endfunction

  function automatic void add_typed(logic cmd, logic [63:0] a, logic [63:0] b,
                                    logic [63:0] m, logic [63:0] rem, logic zero);
    operation_t op;
    op.cmd       = cmd;
    op.a         = a;
    op.b         = b;
    op.m         = m;
    op.typed     = 1'b1;
    op.want.rem  = rem;
    op.want.zero = zero;
    ops.push_back(op);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Operand mixes that hit both carries, near-modulus values and tiny moduli.
  function automatic logic [63:0] shaped64();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 7);
      3: return rand64() >> $urandom_range(0, 63);
      4: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  initial begin : build_ops
    logic [63:0] mx;
    operation_t  op;
    mx = 64'hFFFF_FFFF_FFFF_FFFF;
    add_typed(CMD_ADD, mx, mx, mx, 64'd0, 1'b0);
    add_typed(CMD_MUL, mx, mx, mx, 64'd0, 1'b0);
    add_row(CMD_ADD, mx, mx, mx - 1);
    add_row(CMD_MUL, mx, mx, mx - 1);
    add_typed(CMD_ADD, mx, 64'd1, mx, 64'd1, 1'b0);
    add_typed(CMD_ADD, 64'd0, 64'd0, 64'd1, 64'd0, 1'b0);
    add_typed(CMD_MUL, mx, mx, 64'd1, 64'd0, 1'b0);
    add_typed(CMD_ADD, 64'd5, 64'd7, 64'd0, 64'd0, 1'b1);
    add_typed(CMD_MUL, mx, mx, 64'd0, 64'd0, 1'b1);
    add_typed(CMD_MUL, 64'd0, mx, 64'd3, 64'd0, 1'b0);
    add_row(CMD_MUL, 64'h8000_0000_0000_0000, 64'd2, mx);
    add_row(CMD_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001);
    add_typed(CMD_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 64'h8000_0000_0000_0000,
              64'd0, 1'b0);
    add_row(CMD_MUL, 64'hDEAD_BEEF_CAFE_F00D, 64'h0123_4567_89AB_CDEF, 64'd97);
    add_row(CMD_ADD, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd2);
    repeat (1500) begin
      op.cmd       = $urandom_range(0, 1);
      op.a         = shaped64();
      op.b         = shaped64();
      op.m         = ($urandom_range(0, 19) == 0) ? 64'd0 : shaped64();
      op.typed     = 1'b0;
      op.want.rem  = '0;
      op.want.zero = 1'b0;
      ops.push_back(op);
    end
  end

  // Drive beats at the falling edge in bursts with gaps; predict on acceptance.
  initial begin : sender
    int idx;
    int burst;
    idx = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    while (idx < ops.size()) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && idx < ops.size()) begin
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = ops[idx].cmd;
        s_axis_tdata  = {ops[idx].m, ops[idx].b, ops[idx].a};
        @(posedge clk);
        if (s_axis_tready) begin
          if (ops[idx].typed) pending_residues.push_back(ops[idx].want);
          else pending_residues.push_back(predict_residue(ops[idx]));
          idx++;
          burst--;
        end
        @(negedge clk);
      end
      s_axis_tvalid = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(0, 12)) @(negedge clk);
    end
    s_axis_tvalid = 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver stall pattern, with one long hold-off to fill the pipe.
  initial begin : receiver
    int phase;
    phase = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      phase++;
      if (phase == 400) stall_hold = 600;
      if (stall_hold > 0) begin
        stall_hold--;
        m_axis_tready = 1'b0;
      end else if ((phase / 200) % 2 == 0) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    residue_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_residues.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: rem=%h zero=%b", m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_residues.pop_front();
        if (want.rem !== m_axis_tdata || want.zero !== m_axis_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rem=%h zero=%b, got rem=%h zero=%b",
                     want.rem, want.zero, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  initial begin : finisher
    wait (stimulus_done);
    wait (pending_residues.size() == 0);
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (mismatches == 0 && pending_residues.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
